// ===== rtl/aes128_block_cipher_top_defines.svh =====
// Assertion macros shared by the cipher RTL.
// No dependencies.
`ifndef AES128_BLOCK_CIPHER_TOP_DEFINES_SVH
`define AES128_BLOCK_CIPHER_TOP_DEFINES_SVH
// Concurrent assertion reported with $error, disabled during reset.
`define AES_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Same, but also checked while reset is high.
`define AES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/aes_pkg.sv =====
// Package for the AES-128 cipher: S-box tables, GF helpers, round functions.
// No dependencies.
package aes_pkg;

   localparam int unsigned KeyWords  = 44;
   localparam int unsigned KwAddrW   = 6;
   localparam int unsigned NumRounds = 10;

   typedef logic [7:0]   byte_type;
   typedef logic [31:0]  word_type;
   typedef logic [127:0] blk_type;

   typedef enum logic [1:0] {
      CSR_KEY_HIGH = 2'd0,
      CSR_KEY_LOW  = 2'd1
   } csr_idx_type;

   function automatic byte_type sbox(input byte_type x);
      byte_type t [256] = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic byte_type inv_sbox(input byte_type x);
      byte_type t [256] = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      return t[x];
   endfunction

   // Round constant for key-schedule step n (0..9)
   function automatic byte_type rcon(input logic [3:0] n);
      byte_type r;
      case (n)
         4'd0:    r = 8'h01;
         4'd1:    r = 8'h02;
         4'd2:    r = 8'h04;
         4'd3:    r = 8'h08;
         4'd4:    r = 8'h10;
         4'd5:    r = 8'h20;
         4'd6:    r = 8'h40;
         4'd7:    r = 8'h80;
         4'd8:    r = 8'h1b;
         4'd9:    r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic byte_type xt(input byte_type v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // Rotate then substitute, plus rcon on the top byte
   function automatic word_type sched_f(input word_type w, input logic [3:0] n);
      word_type r;
      r = {w[23:0], w[31:24]};
      return {sbox(r[31:24]) ^ rcon(n), sbox(r[23:16]), sbox(r[15:8]), sbox(r[7:0])};
   endfunction

   // Byte k at bits 127-8k (row k%4, column k/4)
   function automatic blk_type sub_shift(input blk_type s, input logic inv);
      blk_type o;
      int c, r;
      for (c = 0; c < 4; c++) begin
         for (r = 0; r < 4; r++) begin
            if (inv)
               o[127-8*(4*c+r) -: 8] = inv_sbox(s[127-8*(4*((c+4-r)%4)+r) -: 8]);
            else
               o[127-8*(4*c+r) -: 8] = sbox(s[127-8*(4*((c+r)%4)+r) -: 8]);
         end
      end
      return o;
   endfunction

   function automatic word_type mix_col(input word_type a, input logic inv);
      byte_type b [4];
      byte_type d [4];
      byte_type q [4];
      byte_type e [4];
      word_type o;
      int r;
      for (r = 0; r < 4; r++) begin
         b[r] = a[31-8*r -: 8];
         d[r] = xt(b[r]);
         q[r] = xt(d[r]);
         e[r] = xt(q[r]);
      end
      for (r = 0; r < 4; r++) begin
         if (inv)
            // 0e, 0b, 0d, 09
            o[31-8*r -: 8] = (e[r] ^ q[r] ^ d[r]) ^ (e[(r+1)%4] ^ d[(r+1)%4] ^ b[(r+1)%4])
                           ^ (e[(r+2)%4] ^ q[(r+2)%4] ^ b[(r+2)%4]) ^ (e[(r+3)%4] ^ b[(r+3)%4]);
         else
            o[31-8*r -: 8] = d[r] ^ (d[(r+1)%4] ^ b[(r+1)%4]) ^ b[(r+2)%4] ^ b[(r+3)%4];
      end
      return o;
   endfunction

   function automatic blk_type mix_cols(input blk_type s, input logic inv);
      blk_type o;
      int c;
      for (c = 0; c < 4; c++)
         o[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
      return o;
   endfunction

endpackage

// ===== rtl/aes128_block_cipher_top.sv =====
// AES-128 ECB encrypt/decrypt block with key schedule held in a RAM.
// Depends on aes_pkg and aes128_block_cipher_top_defines.svh.
//
// One request (mode, 128-bit block) gives one result. The key schedule's
// 11 round keys sit in a 11 x 128-bit synchronous RAM. After acceptance, a
// block runs the initial key add and ten rounds at one per cycle, then
// loads the result register, which sets result valid. The first round
// key is read at the accepting edge and each round prefetches the key of
// the next. The next request is taken once the result register is free,
// i.e. after the result has been taken. Any key register write starts an
// expansion (key load, then one round key per cycle, read back from the
// RAM); requests wait meanwhile. The same expansion runs after reset for
// the all-zero key.
`include "aes128_block_cipher_top_defines.svh"
module aes128_block_cipher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_high,
   output logic [63:0] rsp_out_low
);
   import aes_pkg::*;

   typedef enum logic [3:0] {
      ST_EXP  = 4'b0001,
      ST_IDLE = 4'b0010,
      ST_RUN  = 4'b0100,
      ST_DONE = 4'b1000
   } st_type;

   // key schedule RAM, one 128-bit round key per entry
   blk_type    rk_mem [NumRounds+1];
   blk_type    rk_rd;
   logic [3:0] rd_addr;
   logic       wr_en;
   logic [3:0] wr_addr;
   blk_type    wr_data;

   st_type     st_ff, st_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [63:0] kh_ff, kl_ff;
   logic       mode_ff;
   blk_type    s_ff, s_in;
   logic       ovld_ff;
   blk_type    o_ff;
   logic       cfg_hit;
   blk_type    t, nk;
   word_type   w0, w1, w2, w3;

   assign cfg_hit = csr_we;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kh_ff <= '0;
         kl_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == 1'(CSR_KEY_HIGH)) kh_ff <= csr_wdata;
         else kl_ff <= csr_wdata;
      end
   end

   // RAM, with the entry being written forwarded to the read port
   always_ff @(posedge clock) begin
      if (wr_en) rk_mem[wr_addr] <= wr_data;
      if (wr_en && wr_addr == rd_addr) rk_rd <= wr_data;
      else rk_rd <= rk_mem[rd_addr];
   end

   // next round key from the previous one
   always_comb begin
      w0 = rk_rd[127:96] ^ sched_f(rk_rd[31:0], cnt_ff - 4'd1);
      w1 = rk_rd[95:64] ^ w0;
      w2 = rk_rd[63:32] ^ w1;
      w3 = rk_rd[31:0] ^ w2;
      nk = {w0, w1, w2, w3};
   end

   assign req_ready = (st_ff == ST_IDLE) && !ovld_ff && !cfg_hit;

   always_comb begin
      st_in   = st_ff;
      cnt_in  = cnt_ff;
      s_in    = s_ff;
      wr_en   = 1'b0;
      wr_addr = cnt_ff;
      wr_data = nk;
      rd_addr = cnt_ff;
      t       = '0;
      case (st_ff)
         ST_EXP: begin
            // cnt 0 writes the key, cnt n>0 writes from entry n-1 read last cycle
            wr_en = 1'b1;
            if (cnt_ff == 4'd0) wr_data = {kh_ff, kl_ff};
            rd_addr = cnt_ff;
            if (cnt_ff == 4'(NumRounds)) st_in = ST_IDLE;
            else cnt_in = cnt_ff + 4'd1;
         end
         ST_IDLE: begin
            rd_addr = req_mode ? 4'(NumRounds) : 4'd0;
            if (req_valid && req_ready) begin
               s_in   = {req_block_high, req_block_low};
               cnt_in = 4'd0;
               st_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            // step cnt uses round (enc: cnt, dec: 10-cnt), prefetch next
            if (cnt_ff != 4'(NumRounds))
               rd_addr = mode_ff ? 4'(NumRounds) - cnt_ff - 4'd1 : cnt_ff + 4'd1;
            if (cnt_ff == 4'd0) s_in = s_ff ^ rk_rd;
            else if (!mode_ff) begin
               t = sub_shift(s_ff, 1'b0);
               if (cnt_ff != 4'(NumRounds)) t = mix_cols(t, 1'b0);
               s_in = t ^ rk_rd;
            end else begin
               t = sub_shift(s_ff, 1'b1) ^ rk_rd;
               s_in = (cnt_ff != 4'(NumRounds)) ? mix_cols(t, 1'b1) : t;
            end
            if (cnt_ff == 4'(NumRounds)) st_in = ST_DONE;
            else cnt_in = cnt_ff + 4'd1;
         end
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
      if (cfg_hit) begin
         st_in  = ST_EXP;
         cnt_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_EXP;
         cnt_ff <= '0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
      end
      s_ff <= s_in;
      if (st_ff == ST_IDLE && req_valid && req_ready) mode_ff <= req_mode;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) ovld_ff <= 1'b0;
      else if (st_ff == ST_DONE) ovld_ff <= 1'b1;
      else if (rsp_ready) ovld_ff <= 1'b0;
      if (st_ff == ST_DONE) o_ff <= s_ff;
   end

   assign rsp_valid    = ovld_ff;
   assign rsp_out_high = o_ff[127:64];
   assign rsp_out_low  = o_ff[63:0];

   `AES_ASSERT(a_no_acc_busy, clock, reset, (req_valid && req_ready) |-> st_ff == ST_IDLE, "accept while busy")
   `AES_ASSERT(a_done_free, clock, reset, (st_ff == ST_DONE) |-> !ovld_ff, "result overwritten")
   `AES_ASSERT(a_run_cnt, clock, reset, (st_ff == ST_RUN) |-> cnt_ff <= 4'(NumRounds), "round count overrun")
   `AES_ASSERT_ALWAYS(a_reset_exp, clock, reset |=> st_ff == ST_EXP, "no expansion after reset")
endmodule
